// ----- rtl/core/rnus_pkg.sv -----
// Shared types and codes for the register next-usage scan.
`timescale 1ns / 1ps

package rnus_pkg;

   // Operand kind codes
   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_GEN   = 3'd1;
   localparam logic [2:0] KIND_FLT   = 3'd2;
   localparam logic [2:0] KIND_VEC   = 3'd3;
   localparam logic [2:0] KIND_PAIR  = 3'd4;

   // Usage codes
   localparam logic [2:0] USAGE_UNKNOWN   = 3'd0;
   localparam logic [2:0] USAGE_READ      = 3'd1;
   localparam logic [2:0] USAGE_WRITE     = 3'd2;
   localparam logic [2:0] USAGE_CLOBBERED = 3'd3;
   localparam logic [2:0] USAGE_UNUSED    = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_REG_CLASS = 2'd0;
   localparam logic [1:0] CSR_QUERY_REG = 2'd1;
   localparam logic [1:0] CSR_LOOKAHEAD = 2'd2;
   localparam logic [1:0] CSR_TEMP_BASE = 2'd3;

   // Tracked range limits
   localparam logic [7:0] GEN_LIMIT      = 8'd32;
   localparam logic [7:0] FLT_HOLE_LO    = 8'd160;
   localparam logic [7:0] FLT_HOLE_HI    = 8'd192;
   localparam logic [7:0] FLT_LIMIT      = 8'd208;
   localparam logic [8:0] VEC_SPAN       = 9'd4;
   localparam logic [8:0] PAIR_SPAN      = 9'd2;

   typedef struct packed {
      logic [2:0] kind_dest;
      logic [2:0] kind_src1;
      logic [2:0] kind_src2;
      logic [7:0] reg_dest;
      logic [7:0] reg_src1;
      logic [7:0] reg_src2;
      logic       has_src3;
      logic       src3_is_dest;
      logic       is_exit;
      logic       is_barrier;
      logic       is_vec4_shuffle;
      logic       block_end;
   } instr_type;

   typedef struct packed {
      logic       reg_class;
      logic [7:0] query_reg;
      logic [7:0] lookahead;
      logic [7:0] temp_base;
   } cfg_type;

   typedef struct packed {
      logic       done;     // scan ends on this word
      logic [2:0] usage;
      logic [7:0] offset;
   } verdict_type;

endpackage

// ----- rtl/core/rnus_decide.sv -----
// Per-instruction classification of the queried register.
`timescale 1ns / 1ps

module rnus_decide (
   input  rnus_pkg::instr_type   instr,
   input  rnus_pkg::cfg_type     cfg,
   input  logic [7:0]            scan_offset,
   output rnus_pkg::verdict_type verdict
);

   function automatic logic in_span(input logic [2:0] kind, input logic [7:0] base,
                                    input logic [7:0] r);
      logic [8:0] b9;
      logic [8:0] r9;
      logic       hit;
      b9 = {1'b0, base};
      r9 = {1'b0, r};
      case (kind)
         rnus_pkg::KIND_FLT:  hit = (r == base);
         rnus_pkg::KIND_VEC:  hit = (r9 >= b9) && (r9 < b9 + rnus_pkg::VEC_SPAN);
         rnus_pkg::KIND_PAIR: hit = (r9 >= b9) && (r9 < b9 + rnus_pkg::PAIR_SPAN);
         default:             hit = 1'b0;
      endcase
      return hit;
   endfunction

   logic       fp;
   logic       untracked;
   logic       temp;
   logic       third_read;
   logic       gen_read;
   logic       gen_write;
   logic       flt_read;
   logic       flt_write;
   logic       bcast;
   logic       at_end;
   logic [2:0] write_usage;
   logic [8:0] next_off;
   logic [7:0] q;

   assign q          = cfg.query_reg;
   assign fp         = cfg.reg_class;
   assign untracked  = fp ? (((q >= rnus_pkg::FLT_HOLE_LO) && (q < rnus_pkg::FLT_HOLE_HI))
                             || (q >= rnus_pkg::FLT_LIMIT))
                          : (q >= rnus_pkg::GEN_LIMIT);
   assign temp       = (q >= cfg.temp_base);
   assign third_read = instr.has_src3 | instr.src3_is_dest;

   assign gen_read  = ((instr.kind_src1 == rnus_pkg::KIND_GEN) && (instr.reg_src1 == q))
                    | ((instr.kind_src2 == rnus_pkg::KIND_GEN) && (instr.reg_src2 == q))
                    | (third_read && (instr.kind_dest == rnus_pkg::KIND_GEN)
                       && (instr.reg_dest == q))
                    | instr.is_exit | instr.is_barrier;
   assign gen_write = !instr.has_src3 && (instr.kind_dest == rnus_pkg::KIND_GEN)
                      && (instr.reg_dest == q);

   assign flt_read  = in_span(instr.kind_src1, instr.reg_src1, q)
                    | in_span(instr.kind_src2, instr.reg_src2, q)
                    | (third_read && in_span(instr.kind_dest, instr.reg_dest, q))
                    | instr.is_exit | instr.is_barrier;
   assign flt_write = !instr.has_src3 && in_span(instr.kind_dest, instr.reg_dest, q);

   // broadcast shuffle: immediate zero, dest aliases src1
   assign bcast = instr.is_vec4_shuffle && (instr.reg_src2 == 8'd0)
                  && (instr.reg_dest == instr.reg_src1);

   assign write_usage = (scan_offset == 8'd0) ? rnus_pkg::USAGE_WRITE
                                              : rnus_pkg::USAGE_CLOBBERED;
   assign next_off    = {1'b0, scan_offset} + 9'd1;
   assign at_end      = (next_off >= {1'b0, cfg.lookahead});

   always_comb begin
      verdict.done   = 1'b1;
      verdict.usage  = rnus_pkg::USAGE_UNUSED;
      verdict.offset = scan_offset;
      if (untracked) begin
         verdict.usage = rnus_pkg::USAGE_UNKNOWN;
      end else if (cfg.lookahead == 8'd0) begin
         verdict.offset = 8'd0;
      end else if (!fp && gen_read) begin
         verdict.usage = rnus_pkg::USAGE_READ;
      end else if (!fp && gen_write) begin
         verdict.usage = write_usage;
      end else if (fp && flt_read && bcast) begin
         verdict.usage = (instr.reg_src1 == q) ? rnus_pkg::USAGE_READ
                                               : rnus_pkg::USAGE_CLOBBERED;
      end else if (fp && flt_read && (!temp || !instr.is_exit)) begin
         verdict.usage = rnus_pkg::USAGE_READ;
      end else if (fp && flt_write) begin
         verdict.usage = write_usage;
      end else if (instr.block_end) begin
         verdict.usage = (fp && temp) ? rnus_pkg::USAGE_CLOBBERED
                                      : rnus_pkg::USAGE_UNUSED;
      end else if (at_end) begin
         verdict.usage = rnus_pkg::USAGE_UNUSED;
      end else begin
         verdict.done = 1'b0;
      end
   end

endmodule

// ----- rtl/core/register_next_usage_scan.sv -----
// Top level of the register next-usage scan: input stage, decision, result stage.
`timescale 1ns / 1ps
// Accepted words are registered in the input stage, deciding verdicts in the result stage.
// Throughput: one instruction word per cycle, sustained while the result side takes words.
// The rate is set by the combinational decision between the input and result registers.
// Reset (synchronous, active high) empties both stages, starts a fresh scan at offset 0
// and loads reg_class=1, query_reg=0, lookahead=8, temp_base=192.

module register_next_usage_scan (
   input  logic       clock,
   input  logic       reset,
   // instruction words
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind_dest,
   input  logic [2:0] req_kind_src1,
   input  logic [2:0] req_kind_src2,
   input  logic [7:0] req_reg_dest,
   input  logic [7:0] req_reg_src1,
   input  logic [7:0] req_reg_src2,
   input  logic       req_has_src3,
   input  logic       req_src3_is_dest,
   input  logic       req_is_exit,
   input  logic       req_is_barrier,
   input  logic       req_is_vec4_shuffle,
   input  logic       req_block_end,
   // result words
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_usage,
   output logic [7:0] rsp_offset,
   // configuration
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // configuration registers
   rnus_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reg_class <= 1'b1;
         cfg_ff.query_reg <= 8'd0;
         cfg_ff.lookahead <= 8'd8;
         cfg_ff.temp_base <= 8'd192;
      end else if (csr_wr_en) begin
         case (csr_index)
            rnus_pkg::CSR_REG_CLASS: cfg_ff.reg_class <= csr_wdata[0];
            rnus_pkg::CSR_QUERY_REG: cfg_ff.query_reg <= csr_wdata;
            rnus_pkg::CSR_LOOKAHEAD: cfg_ff.lookahead <= csr_wdata;
            rnus_pkg::CSR_TEMP_BASE: cfg_ff.temp_base <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   logic                  in_valid_ff;
   rnus_pkg::instr_type   instr_ff;
   rnus_pkg::instr_type   instr_in;
   rnus_pkg::verdict_type verdict;
   logic [7:0]            scan_offset_ff;
   logic [7:0]            scan_offset_in;
   logic                  out_free;
   logic                  advance;
   logic                  req_fire;

   // result stage
   logic                  rsp_valid_ff;
   logic [2:0]            usage_ff;
   logic [7:0]            offset_ff;

   assign instr_in = '{kind_dest:       req_kind_dest,
                       kind_src1:       req_kind_src1,
                       kind_src2:       req_kind_src2,
                       reg_dest:        req_reg_dest,
                       reg_src1:        req_reg_src1,
                       reg_src2:        req_reg_src2,
                       has_src3:        req_has_src3,
                       src3_is_dest:    req_src3_is_dest,
                       is_exit:         req_is_exit,
                       is_barrier:      req_is_barrier,
                       is_vec4_shuffle: req_is_vec4_shuffle,
                       block_end:       req_block_end};

   rnus_decide u_decide (
      .instr       (instr_ff),
      .cfg         (cfg_ff),
      .scan_offset (scan_offset_ff),
      .verdict     (verdict)
   );

   // A word that ends the scan needs room in the result stage; one that does not
   // just moves the offset on.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!verdict.done || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign scan_offset_in = verdict.done ? 8'd0 : (scan_offset_ff + 8'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         scan_offset_ff <= 8'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            scan_offset_ff <= scan_offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         instr_ff <= instr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && verdict.done;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && verdict.done) begin
         usage_ff  <= verdict.usage;
         offset_ff <= verdict.offset;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_usage  = usage_ff;
   assign rsp_offset = offset_ff;

endmodule

// ----- rtl/core/rnus_checker.sv -----
// Port-level checks for the register next-usage scan, bound to the top level.
`timescale 1ns / 1ps

module rnus_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_usage,
   input logic [7:0] rsp_offset
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_usage) && $stable(rsp_offset))
      else $error("result word changed while stalled");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // usage code in range
   a_usage_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_usage <= rnus_pkg::USAGE_UNUSED))
      else $error("usage code out of range");

   // a first-position write is the only WRITE
   a_write_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_usage == rnus_pkg::USAGE_WRITE) |-> (rsp_offset == 8'd0))
      else $error("WRITE reported at non-zero offset");

endmodule

bind register_next_usage_scan rnus_checker u_rnus_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_usage  (rsp_usage),
   .rsp_offset (rsp_offset)
);

// ----- bench/tb_register_next_usage_scan.sv -----
// Self-checking bench for the register next-usage scan: driven words, predicted verdicts.
`timescale 1ns / 1ps

module tb_register_next_usage_scan;

   localparam int HOLD_OFF_CYCLES = 300;  // long result-side hold-off
   localparam int SETTLE_CYCLES   = 8;    // covers the two-stage pipe after the last verdict
   localparam int RANDOM_WORDS    = 580;

   // One expected verdict: usage code and the offset of the deciding word
   typedef struct {
      logic [2:0] usage;
      logic [7:0] offset;
   } usage_verdict_type;

   // Scoreboard: own copy of the CSRs and the scan position, verdict queue in order
   class usage_scoreboard_type;
      logic              reg_class;
      logic [7:0]        query_reg;
      logic [7:0]        lookahead;
      logic [7:0]        temp_base;
      logic [7:0]        scan_pos;
      usage_verdict_type verdicts_due[$];
      int                errors;
      int                words_seen;
      int                results_seen;
      int                usage_count[5];

      function new();
         reg_class = 1'b1;
         query_reg = 8'd0;
         lookahead = 8'd8;
         temp_base = 8'd192;
         scan_pos  = 8'd0;
      endfunction

      function void write_reg(logic [1:0] index, logic [7:0] value);
         case (index)
            rnus_pkg::CSR_REG_CLASS: reg_class = value[0];
            rnus_pkg::CSR_QUERY_REG: query_reg = value;
            rnus_pkg::CSR_LOOKAHEAD: lookahead = value;
            rnus_pkg::CSR_TEMP_BASE: temp_base = value;
            default: ;
         endcase
      endfunction

      // Does an operand of this kind, based at base, cover register r? No wrap past 255.
      function bit covers(logic [2:0] kind, logic [7:0] base, logic [7:0] r);
         int b;
         b = base;
         case (kind)
            rnus_pkg::KIND_FLT:  return r == base;
            rnus_pkg::KIND_VEC:
               return int'(r) >= b && int'(r) < b + int'(rnus_pkg::VEC_SPAN);
            rnus_pkg::KIND_PAIR:
               return int'(r) >= b && int'(r) < b + int'(rnus_pkg::PAIR_SPAN);
            default:   return 1'b0;
         endcase
      endfunction

      function void close_scan(logic [2:0] usage, logic [7:0] offset);
         usage_verdict_type v;
         v.usage  = usage;
         v.offset = offset;
         verdicts_due.push_back(v);
         scan_pos = 8'd0;
      endfunction

      // Accepted instruction word: advance the scan, queue a verdict if it decides
      function void note_word(rnus_pkg::instr_type w);
         bit         fp;
         bit         temp;
         bit         third;
         bit         hit;
         logic [7:0] q;
         logic [7:0] off;
         fp    = reg_class;
         temp  = 1'b0;
         third = w.has_src3 || w.src3_is_dest;
         q     = query_reg;
         off   = scan_pos;
         words_seen++;

         // untracked registers answer at once
         if (fp) begin
            if ((q >= rnus_pkg::FLT_HOLE_LO && q < rnus_pkg::FLT_HOLE_HI) ||
                q >= rnus_pkg::FLT_LIMIT) begin
               close_scan(rnus_pkg::USAGE_UNKNOWN, off);
               return;
            end
            temp = q >= temp_base;
         end else if (q >= rnus_pkg::GEN_LIMIT) begin
            close_scan(rnus_pkg::USAGE_UNKNOWN, off);
            return;
         end

         if (lookahead == 8'd0) begin
            close_scan(rnus_pkg::USAGE_UNUSED, 8'd0);
            return;
         end

         if (!fp) begin
            hit = (w.kind_src1 == rnus_pkg::KIND_GEN && w.reg_src1 == q) ||
                  (w.kind_src2 == rnus_pkg::KIND_GEN && w.reg_src2 == q) ||
                  (third && w.kind_dest == rnus_pkg::KIND_GEN && w.reg_dest == q) ||
                  w.is_exit || w.is_barrier;
            if (hit) begin
               close_scan(rnus_pkg::USAGE_READ, off);
               return;
            end
            if (!w.has_src3 && w.kind_dest == rnus_pkg::KIND_GEN && w.reg_dest == q) begin
               close_scan(off == 8'd0 ? rnus_pkg::USAGE_WRITE : rnus_pkg::USAGE_CLOBBERED,
                          off);
               return;
            end
         end else begin
            hit = covers(w.kind_src1, w.reg_src1, q) || covers(w.kind_src2, w.reg_src2, q) ||
                  (third && covers(w.kind_dest, w.reg_dest, q)) ||
                  w.is_exit || w.is_barrier;
            if (hit) begin
               // broadcast shuffle overwrites every lane but the source one
               if (w.is_vec4_shuffle && w.reg_src2 == 8'd0 && w.reg_dest == w.reg_src1) begin
                  close_scan(w.reg_src1 == q ? rnus_pkg::USAGE_READ
                                             : rnus_pkg::USAGE_CLOBBERED, off);
                  return;
               end
               // exits do not keep temporaries alive
               if (!temp || !w.is_exit) begin
                  close_scan(rnus_pkg::USAGE_READ, off);
                  return;
               end
            end
            if (!w.has_src3 && covers(w.kind_dest, w.reg_dest, q)) begin
               close_scan(off == 8'd0 ? rnus_pkg::USAGE_WRITE : rnus_pkg::USAGE_CLOBBERED,
                          off);
               return;
            end
         end

         if (w.block_end) begin
            close_scan((fp && temp) ? rnus_pkg::USAGE_CLOBBERED : rnus_pkg::USAGE_UNUSED,
                       off);
            return;
         end
         if (int'(off) + 1 >= int'(lookahead)) begin
            close_scan(rnus_pkg::USAGE_UNUSED, off);
            return;
         end
         scan_pos = off + 8'd1;
      endfunction

      // Accepted result word against the oldest verdict due
      function void check_result(logic [2:0] usage, logic [7:0] offset);
         usage_verdict_type v;
         if (verdicts_due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing due, usage %0d offset %0d",
                     $time, usage, offset);
            return;
         end
         v = verdicts_due.pop_front();
         results_seen++;
         if (usage <= rnus_pkg::USAGE_UNUSED)
            usage_count[usage]++;
         if (usage !== v.usage) begin
            errors++;
            $display("%0t: usage mismatch, expected %0d actual %0d", $time, v.usage, usage);
         end
         if (offset !== v.offset) begin
            errors++;
            $display("%0t: offset mismatch, expected %0d actual %0d", $time, v.offset, offset);
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------------------------
   // Block inputs: all known from time zero
   // ---------------------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   rnus_pkg::instr_type req_word = '0;
   logic                rsp_ready = 1'b0;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = rnus_pkg::CSR_REG_CLASS;
   logic [7:0]          csr_wdata = 8'd0;

   logic       req_ready;
   logic       rsp_valid;
   logic [2:0] rsp_usage;
   logic [7:0] rsp_offset;

   usage_scoreboard_type sb;
   bit steady = 1'b0;         // no idling on either side while set
   bit hold_off_req = 1'b0;   // asks the receiver for one long hold-off
   int settings_used = 0;

   register_next_usage_scan DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind_dest       (req_word.kind_dest),
      .req_kind_src1       (req_word.kind_src1),
      .req_kind_src2       (req_word.kind_src2),
      .req_reg_dest        (req_word.reg_dest),
      .req_reg_src1        (req_word.reg_src1),
      .req_reg_src2        (req_word.reg_src2),
      .req_has_src3        (req_word.has_src3),
      .req_src3_is_dest    (req_word.src3_is_dest),
      .req_is_exit         (req_word.is_exit),
      .req_is_barrier      (req_word.is_barrier),
      .req_is_vec4_shuffle (req_word.is_vec4_shuffle),
      .req_block_end       (req_word.block_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_usage           (rsp_usage),
      .rsp_offset          (rsp_offset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timeout: run did not complete");
      $display("TEST FAILED");
      $finish;
   end

   // Monitor: everything sampled at the edge, pre-update values only
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_word(req_word);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_usage, rsp_offset);
      end
   end

   // Gap lengths: mostly none or short, now and then long
   function automatic int pick_gap(int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request, counted here
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++)
               @(posedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 30)
               stall_left = pick_gap(0);
         end
      end
   end

   // Sender: one word, optional gap first, held until taken. Valid stays up on exit so
   // a back-to-back word follows without a drop; drain lowers it.
   task automatic send_word(input rnus_pkg::instr_type w);
      int gap;
      gap = steady ? 0 : pick_gap(60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering, wait for every verdict due, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // All four CSRs, one per cycle; only called with the block idle
   task automatic apply_config(input logic rc, input logic [7:0] q, la, tb);
      csr_wr_en <= 1'b1;
      csr_index <= rnus_pkg::CSR_REG_CLASS;
      csr_wdata <= {7'd0, rc};
      @(posedge clock);
      csr_index <= rnus_pkg::CSR_QUERY_REG;
      csr_wdata <= q;
      @(posedge clock);
      csr_index <= rnus_pkg::CSR_LOOKAHEAD;
      csr_wdata <= la;
      @(posedge clock);
      csr_index <= rnus_pkg::CSR_TEMP_BASE;
      csr_wdata <= tb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   function automatic rnus_pkg::instr_type op(logic [2:0] kd, k1, k2, logic [7:0] rd, r1, r2,
                                              logic s3, s3d, ex, bar, shuf, bend);
      rnus_pkg::instr_type w;
      w.kind_dest       = kd;
      w.kind_src1       = k1;
      w.kind_src2       = k2;
      w.reg_dest        = rd;
      w.reg_src1        = r1;
      w.reg_src2        = r2;
      w.has_src3        = s3;
      w.src3_is_dest    = s3d;
      w.is_exit         = ex;
      w.is_barrier      = bar;
      w.is_vec4_shuffle = shuf;
      w.block_end       = bend;
      return w;
   endfunction

   // Kinds: mostly real operand types, sometimes the spare codes
   function automatic logic [2:0] rand_kind();
      if ($urandom_range(0, 9) < 9)
         return 3'($urandom_range(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_PAIR));
      return 3'($urandom_range(5, 7));
   endfunction

   // Half the operands land within a vector span of the query register
   function automatic logic [7:0] rand_reg(logic [7:0] q);
      if ($urandom_range(0, 1))
         return q + 8'($urandom_range(0, 6)) - 8'd3;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic rnus_pkg::instr_type rand_word();
      rnus_pkg::instr_type w;
      logic [7:0]          q;
      q = sb.query_reg;
      w = op(rand_kind(), rand_kind(), rand_kind(), rand_reg(q), rand_reg(q), rand_reg(q),
             $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 10,
             $urandom_range(0, 99) < 8,  $urandom_range(0, 99) < 5,
             $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 10);
      // broadcast form of the shuffle needs a zero immediate and dest == src1
      if (w.is_vec4_shuffle && $urandom_range(0, 1)) begin
         w.reg_src2 = 8'd0;
         w.reg_dest = w.reg_src1;
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int         random_words;
      int         n;
      logic       rc;
      logic [7:0] q;
      logic [7:0] la;
      logic [7:0] tb;

      sb = new();
      random_words = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Out of reset: float query of reg 0, lookahead 8, temporaries from 192
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      // pair at 255 must not wrap round to 0; ends the block unused
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_PAIR,
                   8'd0, 8'd0, 8'd255, 0, 0, 0, 0, 0, 1));
      drain();

      // Float reg 2: spans, shuffles, third slot, exit, barrier, block end
      apply_config(1'b1, 8'd2, 8'd8, 8'd192);
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd2, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_VEC, rnus_pkg::KIND_OTHER,
                   8'd9, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd2, 8'd2, 8'd2, 0, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_VEC, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      // broadcast from lane 0: reg 2 gets overwritten
      send_word(op(rnus_pkg::KIND_VEC, rnus_pkg::KIND_VEC, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 1, 0));
      // broadcast from reg 2 itself: a read
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER,
                   8'd2, 8'd2, 8'd0, 0, 0, 0, 0, 1, 0));
      send_word(op(rnus_pkg::KIND_PAIR, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd1, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd2, 8'd0, 8'd0, 0, 1, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 1, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 0, 1, 0, 0));
      send_word(op(rnus_pkg::KIND_VEC, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd253, 8'd0, 8'd0, 1, 0, 0, 0, 0, 1));
      drain();

      // Temporary 195, lookahead 3: exits ignored, writes clobber, block end clobbers
      apply_config(1'b1, 8'd195, 8'd3, 8'd192);
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 1, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd195, 8'd0, 8'd0, 0, 0, 1, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd0, 8'd0, 0, 0, 1, 0, 0, 1));
      repeat (3)
         send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                      8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      drain();

      // General reg 31, full lookahead
      apply_config(1'b0, 8'd31, 8'd255, 8'd0);
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_GEN,
                   8'd0, 8'd0, 8'd31, 0, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_GEN, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd31, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_GEN, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd31, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0));
      send_word(op(rnus_pkg::KIND_OTHER, rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER,
                   8'd0, 8'd31, 8'd0, 0, 0, 0, 0, 0, 1));
      drain();

      // Untracked registers, then lookahead zero
      apply_config(1'b0, 8'd32, 8'd8, 8'd192);
      send_word(op(rnus_pkg::KIND_GEN, rnus_pkg::KIND_GEN, rnus_pkg::KIND_GEN,
                   8'd32, 8'd32, 8'd32, 0, 0, 0, 0, 0, 0));
      drain();
      apply_config(1'b1, 8'd160, 8'd0, 8'd192);
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_FLT, rnus_pkg::KIND_FLT,
                   8'd160, 8'd160, 8'd160, 0, 0, 0, 0, 0, 0));
      drain();
      apply_config(1'b1, 8'd207, 8'd0, 8'd255);
      send_word(op(rnus_pkg::KIND_FLT, rnus_pkg::KIND_OTHER, rnus_pkg::KIND_OTHER,
                   8'd207, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0));
      drain();

      // Back-pressure: receiver holds off while words keep coming, so the block fills
      apply_config(1'b1, 8'd4, 8'd8, 8'd192);
      steady = 1'b1;
      hold_off_req = 1'b1;
      repeat (40)
         send_word(rand_word());
      steady = 1'b0;
      drain();

      // Random phases, each under a fresh setting; the drain before each write is
      // also the sender pausing until every verdict is back
      while (random_words < RANDOM_WORDS) begin
         rc = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            8:       q = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            9:       q = 8'($urandom_range(0, 255));
            default: q = rc ? ($urandom_range(0, 3) == 0 ? 8'($urandom_range(192, 207))
                                                         : 8'($urandom_range(0, 159)))
                            : 8'($urandom_range(0, 31));
         endcase
         case ($urandom_range(0, 19))
            0:       la = 8'd0;
            1:       la = 8'd255;
            2:       la = 8'd254;
            3:       la = 8'd1;
            default: la = 8'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       tb = 8'd0;
            1:       tb = 8'd255;
            2:       tb = q;
            3:       tb = q + 8'd1;
            4:       tb = 8'($urandom_range(0, 255));
            default: tb = 8'd192;
         endcase
         apply_config(rc, q, la, tb);
         steady = ($urandom_range(0, 9) == 0);
         n = $urandom_range(15, 50);
         repeat (n)
            send_word(rand_word());
         random_words += n;
         steady = 1'b0;
         drain();
      end

      // Anything still due counts against the run
      if (sb.pending() > 0)
         $display("%0t: %0d verdicts never arrived", $time, sb.pending());

      $display("Run covered %0d instruction words under %0d CSR settings, %0d verdicts checked",
               sb.words_seen, settings_used, sb.results_seen);
      $display("Verdicts: unknown %0d, read %0d, write %0d, clobbered %0d, unused %0d",
               sb.usage_count[rnus_pkg::USAGE_UNKNOWN], sb.usage_count[rnus_pkg::USAGE_READ],
               sb.usage_count[rnus_pkg::USAGE_WRITE],
               sb.usage_count[rnus_pkg::USAGE_CLOBBERED],
               sb.usage_count[rnus_pkg::USAGE_UNUSED]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
